[design/ism_pkg.sv]
// ----------------------------------------------------------------------------
// ism_pkg
// Shared types, codes and lattice constants of the Ising spin update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ism_pkg;

    localparam int SIDE_LENGTH = 64;
    localparam int ROW_W       = $clog2(SIDE_LENGTH);
    localparam int INDEX_W     = 6;
    localparam int FRAC_W      = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] COUPLING_FERRO = 2'd0;
    localparam logic [1:0] COUPLING_ANTI  = 2'd1;

    localparam logic [1:0] REG_COUPLING    = 2'd0;
    localparam logic [1:0] REG_THRESH_SMALL = 2'd1;
    localparam logic [1:0] REG_THRESH_LARGE = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] column;
        logic               spin_in;
        logic [FRAC_W-1:0]  random_fraction;
    } in_beat_t;

    typedef struct packed {
        logic [INDEX_W-1:0] row_out;
        logic [INDEX_W-1:0] column_out;
        logic               spin_out;
        logic               flipped;
    } out_beat_t;

    typedef struct packed {
        logic [1:0]        coupling_kind;
        logic [FRAC_W-1:0] threshold_small_step;
        logic [FRAC_W-1:0] threshold_large_step;
    } cfg_t;

    typedef struct packed {
        logic center;
        logic up;
        logic down;
        logic left;
        logic right;
    } nbr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_CENTER,
        ST_EXECUTE
    } state_t;

endpackage

`default_nettype wire

[design/ism_row_ram.sv]
// ----------------------------------------------------------------------------
// ism_row_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ism_row_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

[design/ism_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ism_cfg_regs
// APB register file: coupling kind and the two acceptance thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ism_cfg_regs
    import ism_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_sel;

    assign reg_sel = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_sel)
                REG_COUPLING:     cfg_reg.coupling_kind        <= pwdata[1:0];
                REG_THRESH_SMALL: cfg_reg.threshold_small_step <= pwdata;
                REG_THRESH_LARGE: cfg_reg.threshold_large_step <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_COUPLING:     prdata = {30'd0, cfg_reg.coupling_kind};
            REG_THRESH_SMALL: prdata = cfg_reg.threshold_small_step;
            REG_THRESH_LARGE: prdata = cfg_reg.threshold_large_step;
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[design/ism_accept.sv]
// ----------------------------------------------------------------------------
// ism_accept
// Metropolis acceptance: energy change from the neighbor spins and the
// threshold compare against the random fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ism_accept
    import ism_pkg::*;
(
    input  wire nbr_t              nbr,
    input  wire cfg_t              cfg,
    input  wire logic [FRAC_W-1:0] random_fraction,
    output logic                   accept
);

    logic [2:0] aligned;
    logic       de_nonpos;
    logic       de_small;
    logic       below_small;
    logic       below_large;

    assign aligned = 3'(nbr.up    == nbr.center) + 3'(nbr.down  == nbr.center)
                   + 3'(nbr.left  == nbr.center) + 3'(nbr.right == nbr.center);

    assign below_small = random_fraction < cfg.threshold_small_step;
    assign below_large = random_fraction < cfg.threshold_large_step;

    always_comb begin
        case (cfg.coupling_kind)
            COUPLING_FERRO: begin
                de_nonpos = aligned <= 3'd2;
                de_small  = aligned == 3'd3;
            end
            COUPLING_ANTI: begin
                de_nonpos = aligned >= 3'd2;
                de_small  = aligned == 3'd1;
            end
            default: begin
                de_nonpos = 1'b1;
                de_small  = 1'b0;
            end
        endcase
        if (de_nonpos) begin
            accept = 1'b1;
        end else if (de_small) begin
            accept = below_small;
        end else begin
            accept = below_large;
        end
    end

endmodule

`default_nettype wire

[design/ising_metropolis_spin_update.sv]
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Periodic square lattice of one-bit spins with write, read and single-spin
// Metropolis update, kept row-wise in an on-chip RAM.
//
//   channel  dir  handshake               beat
//   s_       in   s_valid / s_ready       s_data  (in_beat_t)
//   m_       out  m_valid / m_ready       m_data  (out_beat_t)
//   apb      in   psel/penable/pwrite     paddr, pwdata, prdata
//
// Per item: the accept cycle (ST_IDLE) reads the rows above and below on
// both RAM read ports, ST_READ_CENTER reads the site's own row, ST_EXECUTE
// decides and writes the row back; s_ready is high only in ST_IDLE. Each row
// has a valid bit cleared at reset, so an unwritten row reads as all zero and
// no clearing pass is needed. A result waiting on m_ready holds ST_EXECUTE; a
// new item can be taken while the previous result is in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ising_metropolis_spin_update
    import ism_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_beat_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_beat_t                  m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t cfg;

    ism_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;

    logic [ROW_W-1:0]       row_in, col_in;
    logic [ROW_W-1:0]       row_up, row_down;
    logic [ROW_W-1:0]       row_reg, col_reg, col_l_reg, col_r_reg;
    logic [1:0]             mode_reg;
    logic                   spin_in_reg;
    logic [FRAC_W-1:0]      rnd_reg;

    logic [SIDE_LENGTH-1:0] valid_reg;
    logic                   valid_a_reg, valid_b_reg;
    logic [SIDE_LENGTH-1:0] up_row_reg, down_row_reg;
    logic [SIDE_LENGTH-1:0] rdata_a, rdata_b, cur_row, new_row;

    logic                   ram_re, ram_we;
    logic [ROW_W-1:0]       raddr_a, raddr_b;
    logic                   take_in, out_free;

    nbr_t                   nbr;
    logic                   accept, new_spin, flip;

    logic                   m_valid_reg;
    out_beat_t              m_data_reg;

    assign row_in   = ROW_W'(s_data.row % SIDE_LENGTH);
    assign col_in   = ROW_W'(s_data.column % SIDE_LENGTH);
    assign row_up   = (row_in == '0) ? ROW_W'(SIDE_LENGTH - 1) : row_in - 1'b1;
    assign row_down = (row_in == ROW_W'(SIDE_LENGTH - 1)) ? '0 : row_in + 1'b1;

    assign s_ready  = state_reg == ST_IDLE;
    assign take_in  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        raddr_a    = row_reg;
        raddr_b    = row_reg;
        case (state_reg)
            ST_IDLE: begin
                raddr_a = row_up;
                raddr_b = row_down;
                if (take_in) begin
                    ram_re     = 1'b1;
                    state_next = ST_READ_CENTER;
                end
            end
            ST_READ_CENTER: begin
                ram_re     = 1'b1;
                state_next = ST_EXECUTE;
            end
            ST_EXECUTE: begin
                if (out_free) begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            row_reg     <= row_in;
            col_reg     <= col_in;
            col_l_reg   <= (col_in == '0) ? ROW_W'(SIDE_LENGTH - 1) : col_in - 1'b1;
            col_r_reg   <= (col_in == ROW_W'(SIDE_LENGTH - 1)) ? '0 : col_in + 1'b1;
            mode_reg    <= s_data.mode;
            spin_in_reg <= s_data.spin_in;
            rnd_reg     <= s_data.random_fraction;
        end
        if (ram_re) begin
            valid_a_reg <= valid_reg[raddr_a];
            valid_b_reg <= valid_reg[raddr_b];
        end
        if (state_reg == ST_READ_CENTER) begin
            up_row_reg   <= rdata_a & {SIDE_LENGTH{valid_a_reg}};
            down_row_reg <= rdata_b & {SIDE_LENGTH{valid_b_reg}};
        end
    end

    // per-row valid bits: unwritten rows read as all zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[row_reg] <= 1'b1;
        end
    end

    ism_row_ram #(
        .DEPTH (SIDE_LENGTH),
        .WIDTH (SIDE_LENGTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (row_reg),
        .wdata   (new_row),
        .re      (ram_re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign cur_row    = rdata_a & {SIDE_LENGTH{valid_a_reg}};
    assign nbr.center = cur_row[col_reg];
    assign nbr.left   = cur_row[col_l_reg];
    assign nbr.right  = cur_row[col_r_reg];
    assign nbr.up     = up_row_reg[col_reg];
    assign nbr.down   = down_row_reg[col_reg];

    ism_accept u_accept (
        .nbr             (nbr),
        .cfg             (cfg),
        .random_fraction (rnd_reg),
        .accept          (accept)
    );

    always_comb begin
        flip     = 1'b0;
        new_spin = nbr.center;
        case (mode_reg)
            MODE_WRITE: new_spin = spin_in_reg;
            MODE_UPDATE: begin
                flip     = accept;
                new_spin = nbr.center ^ accept;
            end
            MODE_READ: new_spin = nbr.center;
            default:   new_spin = nbr.center;
        endcase
        new_row          = cur_row;
        new_row[col_reg] = new_spin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ram_we) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            m_data_reg.row_out    <= INDEX_W'(row_reg);
            m_data_reg.column_out <= INDEX_W'(col_reg);
            m_data_reg.spin_out   <= new_spin;
            m_data_reg.flipped    <= flip;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
